// File: design/nsc_pkg.sv
package nsc_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int CHUNK_W     = 31;
    localparam int TOTAL_W     = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PATTERN_LOW    = 2'd0;
    localparam t_cfg_idx REG_PATTERN_HIGH   = 2'd1;
    localparam t_cfg_idx REG_PATTERN_LENGTH = 2'd2;

    typedef logic [MAX_PATTERN-1:0][7:0] t_byte_arr;

    // Pattern as seen by the matcher: bytes, clamped length and whether the
    // used bytes are all nonzero.
    typedef struct packed {
        t_byte_arr        bytes;
        logic [LEN_W-1:0] len;
        logic             ok;
    } t_pat;

endpackage

// File: design/nonoverlap_substring_counter.sv
// Counts leftmost, non-overlapping occurrences of a 1 to 16 byte pattern in a
// byte stream, chunk by chunk.
// Input channel: i_in_valid with i_data_byte and i_chunk_end; the block stalls
// the sender with o_in_stall. A request is taken at a rising edge where
// i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with o_match_here, o_chunk_matches,
// o_total_matches and o_chunk_done; the receiver stalls with i_out_stall.
// Every input request yields exactly one result. An accepted byte sits in the
// input register and is then scanned into the result register, which drives
// the outputs. Throughput is one byte per cycle while the receiver does not
// stall; the history compare between the two registers is combinational.
// When the receiver stalls, the result holds, one more byte waits in the input
// register, and then o_in_stall rises until the result is taken.
// The pattern registers are written through i_cfg_we / i_cfg_index /
// i_cfg_data; the user must write them only while no byte is in flight, and
// the block itself does not enforce this. A new pattern applies to later
// bytes. Reset clears the history, all counters and the pattern, and sets the
// pattern length to one.
module nonoverlap_substring_counter
    import nsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_chunk_end,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_match_here,
    output logic [CHUNK_W-1:0]    o_chunk_matches,
    output logic [TOTAL_W-1:0]    o_total_matches,
    output logic                  o_chunk_done
);

    t_pat pat;

    nsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pat       (pat)
    );

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Scan state.
    t_byte_arr        r_history, n_history;
    logic [LEN_W-1:0] r_fresh, n_fresh;
    logic             r_stopped, n_stopped;
    logic [CHUNK_W-1:0] r_chunk, n_chunk;
    logic [TOTAL_W-1:0] r_total, n_total;

    // Result register.
    logic               r_out_valid;
    logic               r_hit, n_hit;
    logic [CHUNK_W-1:0] r_chunk_out;
    logic [TOTAL_W-1:0] r_total_out;
    logic               r_done;

    logic advance;
    logic take_in;
    logic window_hit;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    always_comb begin
        n_history = {r_history[MAX_PATTERN-2:0], r_byte};
    end

    nsc_match u_match (
        .i_history (n_history),
        .i_pat     (pat),
        .o_hit     (window_hit)
    );

    always_comb begin
        logic [LEN_W-1:0] fresh_inc;
        n_fresh   = r_fresh;
        n_stopped = r_stopped;
        n_chunk   = r_chunk;
        n_total   = r_total;
        n_hit     = 1'b0;
        fresh_inc = r_fresh;
        if (r_fresh < LEN_W'(MAX_PATTERN)) begin
            fresh_inc = r_fresh + LEN_W'(1);
        end
        if (!r_stopped) begin
            if (r_byte == 8'd0) begin
                n_stopped = 1'b1;
            end else begin
                n_fresh = fresh_inc;
                // All bytes of the window must be new since the last match.
                if (fresh_inc >= pat.len && window_hit) begin
                    n_hit   = 1'b1;
                    n_fresh = '0;
                    if (!(&r_chunk)) begin
                        n_chunk = r_chunk + CHUNK_W'(1);
                    end
                    if (!(&r_total)) begin
                        n_total = r_total + TOTAL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_history   <= '0;
            r_fresh     <= '0;
            r_stopped   <= 1'b0;
            r_chunk     <= '0;
            r_total     <= '0;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (advance) begin
                r_history <= n_history;
                r_total   <= n_total;
                if (r_last) begin
                    r_fresh   <= '0;
                    r_stopped <= 1'b0;
                    r_chunk   <= '0;
                end else begin
                    r_fresh   <= n_fresh;
                    r_stopped <= n_stopped;
                    r_chunk   <= n_chunk;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_byte <= i_data_byte;
            r_last <= i_chunk_end;
        end
        if (advance) begin
            r_hit       <= n_hit;
            r_chunk_out <= n_chunk;
            r_total_out <= n_total;
            r_done      <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_match_here    = r_hit;
    assign o_chunk_matches = r_chunk_out;
    assign o_total_matches = r_total_out;
    assign o_chunk_done    = r_done;

endmodule

// File: design/nsc_cfg.sv
module nsc_cfg
    import nsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_pat                  o_pat
);

    logic [63:0]      r_pattern_low;
    logic [63:0]      r_pattern_high;
    logic [LEN_W-1:0] r_pattern_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_pattern_length <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data[63:0];
                REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data[63:0];
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [LEN_W-1:0] len;
        logic             ok;
        len = r_pattern_length;
        if (len == '0) begin
            len = LEN_W'(1);
        end
        if (len > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end
        o_pat.bytes = t_byte_arr'({r_pattern_high, r_pattern_low});
        // A zero byte inside the used part of the pattern can never match.
        ok = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < len && o_pat.bytes[i] == 8'd0) begin
                ok = 1'b0;
            end
        end
        o_pat.len = len;
        o_pat.ok  = ok;
    end

endmodule

// File: design/nsc_match.sv
module nsc_match
    import nsc_pkg::*;
(
    input  t_byte_arr i_history,
    input  t_pat      i_pat,
    output logic      o_hit
);

    // One comparator row per possible length; the configured length picks one.
    // The oldest byte of a window lines up with pattern byte 0.
    always_comb begin
        logic m;
        o_hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            m = 1'b1;
            for (int i = 0; i < l; i++) begin
                if (i_history[l-1-i] != i_pat.bytes[i]) begin
                    m = 1'b0;
                end
            end
            if (i_pat.len == LEN_W'(l)) begin
                o_hit = m & i_pat.ok;
            end
        end
    end

endmodule

// File: tb/sv/tb_nonoverlap_substring_counter.sv
module tb_nonoverlap_substring_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;

    localparam t_cfg_idx REG_UNUSED = 2'd3;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] NUL  = 8'h00;

    typedef struct packed {
        logic               hit;
        logic [CHUNK_W-1:0] chunk;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } t_count_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_data_byte = '0;
    logic                  i_chunk_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_match_here;
    logic [CHUNK_W-1:0]    o_chunk_matches;
    logic [TOTAL_W-1:0]    o_total_matches;
    logic                  o_chunk_done;

    // Local copy of the counter state and its registers.
    logic [7:0]         text_hist [MAX_PATTERN] = '{default: 8'h00};
    int                 fresh_run = 0;
    logic               zero_hold = 1'b0;
    logic [CHUNK_W-1:0] chunk_hits = '0;
    logic [TOTAL_W-1:0] total_hits = '0;
    logic [127:0]       pat_bytes = '0;
    logic [4:0]         pat_len_reg = 5'd1;

    t_count_result pending_counts [$];
    int            mismatch_cnt = 0;
    int            burst_left = 0;
    int            gap_max = 0;
    logic [7:0]    stall_mask = 8'h00;
    logic [2:0]    rx_phase = 3'd0;
    int            hold_left = 0;

    nonoverlap_substring_counter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_chunk_end     (i_chunk_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_match_here    (o_match_here),
        .o_chunk_matches (o_chunk_matches),
        .o_total_matches (o_total_matches),
        .o_chunk_done    (o_chunk_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int active_len();
        if (pat_len_reg == 5'd0) begin
            return 1;
        end
        if (pat_len_reg > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return pat_len_reg;
    endfunction

    function automatic t_count_result count_next_byte(input logic [7:0] b, input logic last);
        t_count_result r;
        int            len;
        int            i;
        logic          same;
        logic [7:0]    p;
        len = active_len();
        for (i = MAX_PATTERN - 1; i > 0; i--) begin
            text_hist[i] = text_hist[i-1];
        end
        text_hist[0] = b;
        r.hit = 1'b0;
        if (!zero_hold) begin
            if (b == NUL) begin
                zero_hold = 1'b1;
            end else begin
                if (fresh_run < MAX_PATTERN) begin
                    fresh_run++;
                end
                if (fresh_run >= len) begin
                    same = 1'b1;
                    for (i = 0; i < len; i++) begin
                        p = pat_bytes[8*i +: 8];
                        if (p == NUL || text_hist[len-1-i] != p) begin
                            same = 1'b0;
                        end
                    end
                    if (same) begin
                        r.hit = 1'b1;
                        fresh_run = 0;
                        if (chunk_hits != '1) begin
                            chunk_hits++;
                        end
                        if (total_hits != '1) begin
                            total_hits++;
                        end
                    end
                end
            end
        end
        r.chunk = chunk_hits;
        r.total = total_hits;
        r.done  = last;
        if (last) begin
            chunk_hits = '0;
            fresh_run  = 0;
            zero_hold  = 1'b0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_cnt < 40) begin
            $display("%0t: %s", $time, what);
        end
        mismatch_cnt++;
    endtask

    // Each accepted result is checked against the oldest pending prediction.
    always @(posedge i_clk) begin : check_results
        t_count_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_counts.size() == 0) begin
                flag_mismatch("result arrived with no pending request");
            end else begin
                want = pending_counts.pop_front();
                if (o_match_here !== want.hit) begin
                    flag_mismatch($sformatf("match_here %b, expected %b",
                                            o_match_here, want.hit));
                end
                if (o_chunk_matches !== want.chunk) begin
                    flag_mismatch($sformatf("chunk_matches %0d, expected %0d",
                                            o_chunk_matches, want.chunk));
                end
                if (o_total_matches !== want.total) begin
                    flag_mismatch($sformatf("total_matches %0d, expected %0d",
                                            o_total_matches, want.total));
                end
                if (o_chunk_done !== want.done) begin
                    flag_mismatch($sformatf("chunk_done %b, expected %b",
                                            o_chunk_done, want.done));
                end
            end
        end
    end

    // Receiver: a long hold when one is asked for, no stall while the mask is
    // clear, otherwise a rotating stall mask with an occasional random flip.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (stall_mask == 8'h00) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= stall_mask[rx_phase] ^ ($urandom_range(0, 15) == 0);
        end
        rx_phase <= rx_phase + 3'd1;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    pat_bytes[63:0]   = data;
            REG_PATTERN_HIGH:   pat_bytes[127:64] = data;
            REG_PATTERN_LENGTH: pat_len_reg       = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        t_count_result r;
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_chunk_end <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        r = count_next_byte(b, last);
        pending_counts.push_back(r);
    endtask

    task automatic send_str(input string s, input logic last_on_end);
        int k;
        for (k = 0; k < s.len(); k++) begin
            send_byte(s[k], last_on_end && (k == s.len() - 1));
        end
    endtask

    // Stop offering bytes and let every pending result come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_random_pattern(input int style);
        logic [127:0]          bytes;
        logic [4:0]            len_raw;
        logic [CFG_DATA_W-1:0] w;
        int                    eff;
        int                    k;
        for (k = 0; k < MAX_PATTERN; k++) begin
            if ($urandom_range(0, 9) < 6) begin
                bytes[8*k +: 8] = $urandom_range(0, 1) ? CH_A : CH_B;
            end else begin
                bytes[8*k +: 8] = 8'($urandom_range(1, 255));
            end
        end
        case ($urandom_range(0, 9))
            0:       len_raw = 5'd0;
            1:       len_raw = 5'($urandom_range(17, 31));
            default: len_raw = 5'($urandom_range(1, 16));
        endcase
        if (style == 0) begin
            bytes   = '1;
            len_raw = 5'd16;
        end else if (style == 1) begin
            len_raw = 5'd31;
        end
        eff = (len_raw == 5'd0) ? 1 : ((len_raw > MAX_PATTERN) ? MAX_PATTERN : len_raw);
        // Now and then a zero byte inside the used part, which can never match.
        if (style > 1 && $urandom_range(0, 7) == 0) begin
            k = $urandom_range(0, eff - 1);
            bytes[8*k +: 8] = NUL;
        end
        write_reg(REG_PATTERN_LOW, bytes[63:0]);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, {$urandom, $urandom});
        end
        write_reg(REG_PATTERN_HIGH, bytes[127:64]);
        w = {$urandom, $urandom};
        w[4:0] = len_raw;
        write_reg(REG_PATTERN_LENGTH, w);
    endtask

    // Text built mostly from copies and pieces of the current pattern so that
    // matches, overlaps and near misses are frequent.
    task automatic feed_phase(input int count);
        logic [7:0] feed [$];
        logic [7:0] t;
        int         eff;
        int         n;
        int         k;
        int         r;
        eff = active_len();
        n = 0;
        while (n < count) begin
            if (feed.size() == 0) begin
                r = $urandom_range(0, 19);
                if (r < 10) begin
                    for (k = 0; k < eff; k++) begin
                        feed.push_back(pat_bytes[8*k +: 8]);
                    end
                end else if (r < 16) begin
                    repeat ($urandom_range(1, 4)) begin
                        k = $urandom_range(0, eff - 1);
                        feed.push_back(pat_bytes[8*k +: 8]);
                    end
                end else if (r < 19) begin
                    t = 8'($urandom_range(0, 255));
                    feed.push_back(t);
                end else begin
                    feed.push_back(NUL);
                end
            end
            send_byte(feed.pop_front(), $urandom_range(0, 23) == 0);
            n++;
        end
    endtask

    task automatic test_reset_defaults();
        // All-zero pattern after reset: nothing may match.
        send_byte(NUL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        wait_idle();
    endtask

    task automatic test_single_byte_pattern();
        write_reg(REG_PATTERN_LOW, {56'h0, CH_A});
        // A length of zero behaves as a length of one.
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        send_str("aaba", 1'b1);
        send_byte(CH_A, 1'b0);
        send_byte(NUL, 1'b0);
        send_str("aa", 1'b1);
        wait_idle();
    endtask

    task automatic test_non_overlap_and_chunks();
        write_reg(REG_PATTERN_LOW, {48'h0, CH_A, CH_A});
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        // The third byte closes the chunk; the next byte must not complete a
        // match with bytes of the old chunk.
        send_str("aaa", 1'b1);
        send_str("aaa", 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_pattern_byte();
        write_reg(REG_PATTERN_LOW, {48'h0, NUL, CH_A});
        send_byte(CH_A, 1'b0);
        send_byte(NUL, 1'b0);
        send_str("aa", 1'b1);
        wait_idle();
        write_reg(REG_PATTERN_LOW, {48'h0, CH_B, CH_A});
        write_reg(REG_UNUSED, 64'd1);
        send_str("ab", 1'b0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        gap_max    = 0;
        stall_mask = 8'h00;
        load_random_pattern(2);
        @(posedge i_clk);
        hold_left = 300;
        @(negedge i_clk);
        feed_phase(60);
        wait_idle();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int ph;
        for (ph = 0; ph < phases; ph++) begin
            if (ph % 4 == 3) begin
                gap_max    = 0;
                stall_mask = 8'h00;
            end else begin
                gap_max    = $urandom_range(1, 6);
                stall_mask = 8'($urandom_range(1, 255));
                stall_mask[$urandom_range(0, 7)] = 1'b0;
            end
            load_random_pattern(ph);
            feed_phase(per_phase);
            wait_idle();
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        gap_max    = 2;
        stall_mask = 8'b0010_0100;
        test_reset_defaults();
        test_single_byte_pattern();
        test_non_overlap_and_chunks();
        test_zero_pattern_byte();
        test_backpressure();
        test_random_phases(12, 155);
        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/nsc_pkg.sv
design/nsc_cfg.sv
design/nsc_match.sv
design/nonoverlap_substring_counter.sv
tb/sv/tb_nonoverlap_substring_counter.sv
